// ----- src/gww_pkg.sv -----
// Shared constants, result codes and helpers for the greedy word wrap block.
package gww_pkg;

  localparam int unsigned MAX_COLUMNS = 16;
  localparam int unsigned STORE_AW    = $clog2(MAX_COLUMNS);

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] SPACE_BYTE   = 8'd32;
  localparam logic [7:0] TAB_BYTE     = 8'd9;
  localparam logic [7:0] CR_BYTE      = 8'd13;

  localparam logic [4:0] COLUMNS_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_BREAK = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Whitespace: tab through carriage return, and space.
  function automatic logic is_ws(input logic [7:0] b);
    is_ws = (b == SPACE_BYTE) || ((b >= TAB_BYTE) && (b <= CR_BYTE));
  endfunction

  // Clamp the column register into 1 .. MAX_COLUMNS.
  function automatic logic [4:0] eff_cols(input logic [4:0] c);
    logic [4:0] r;
    if (c == 5'd0) begin
      r = 5'd1;
    end else if (c > 5'(MAX_COLUMNS)) begin
      r = 5'(MAX_COLUMNS);
    end else begin
      r = c;
    end
    eff_cols = r;
  endfunction

endpackage

// ----- src/gww_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gww_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/greedy_word_wrap_core.sv -----
// Greedy word wrap: text bytes in, characters, line breaks and end marker out.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_data[4:0]       | in
//   in      | in_valid, in_ready, text_byte, end_of_text| in
//   out     | out_valid, out_ready, kind, out_byte,     | out
//           | final_result                              |
//
// An input transaction is taken only in the idle state; a plain character is
// accepted, then emitted. A buffered word is flushed ahead of the byte that
// ended it: a fit check, then a word store read and an emit per character,
// plus a line break wherever one is due. No new byte is taken until the last
// one is fully handled. The word store has one read port and the add/compare
// unit is a single shared one. Reset (rst, synchronous) clears the sequencer,
// line length, pending flag and word count; the column register returns to 16
// and the word store is left as is. A stalled output holds the sequencer in
// its emit state; cfg_ready is always high.
module greedy_word_wrap_core
  import gww_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,
  // input item channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       final_result
);

  typedef enum logic [2:0] {
    S_IDLE,  // wait for an input transaction
    S_RCHK,  // decide the break before a buffered word
    S_RD,    // issue a word store read
    S_RCHR,  // append a replayed character
    S_RBRK,  // break after a replayed character filled the line
    S_PROC,  // handle the latched byte itself
    S_PBRK,  // break after the latched byte filled the line
    S_END    // end-of-text marker
  } state_t;

  state_t state, state_next;

  logic [4:0]          columns;
  logic [4:0]          line_length, line_length_next;
  logic                word_pending, word_pending_next;
  logic [4:0]          word_count, word_count_next;
  logic [7:0]          byte_q, byte_q_next;
  logic                last_q, last_q_next;
  logic                do_proc, do_proc_next;
  logic [4:0]          rlen, rlen_next;
  logic [STORE_AW-1:0] idx, idx_next;

  logic       out_valid_next, final_result_next;
  logic [1:0] kind_next;
  logic [7:0] out_byte_next;

  // emit request from the sequencer
  logic       emit_en;
  kind_t      emit_kind;
  logic [7:0] emit_byte;
  logic       emit_fin;

  // word store
  logic                ram_we, ram_re;
  logic [7:0]          ram_rdata;

  // shared add/compare unit
  logic [4:0] unit_a, unit_b;
  logic [5:0] sum;
  logic       sum_ge;

  logic [4:0] cw;
  logic       out_free;
  logic       in_ws, byte_ws;
  logic       len_ok;
  logic       idx_done;
  state_t     next_after;
  state_t     after_resolve;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign cw       = eff_cols(columns);
  assign out_free = !out_valid || out_ready;
  assign in_ws    = is_ws(text_byte);
  assign byte_ws  = is_ws(byte_q);
  assign len_ok   = (rlen != 5'd0) && (rlen <= cw);
  assign idx_done = (({1'b0, idx} + 5'd1) == word_count);

  assign sum    = {1'b0, unit_a} + {1'b0, unit_b};
  assign sum_ge = (sum >= {1'b0, cw});

  // Where to go once the current byte is fully handled.
  assign next_after    = last_q ? S_END : S_IDLE;
  assign after_resolve = do_proc ? S_PROC : next_after;

  gww_ram #(
    .WIDTH (8),
    .DEPTH (MAX_COLUMNS)
  ) u_word_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (word_count[STORE_AW-1:0]),
    .wr_data (text_byte),
    .rd_en   (ram_re),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_next        = state;
    line_length_next  = line_length;
    word_pending_next = word_pending;
    word_count_next   = word_count;
    byte_q_next       = byte_q;
    last_q_next       = last_q;
    do_proc_next      = do_proc;
    rlen_next         = rlen;
    idx_next          = idx;
    emit_en           = 1'b0;
    emit_kind         = KIND_CHAR;
    emit_byte         = 8'd0;
    emit_fin          = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    unit_a            = line_length;
    unit_b            = 5'd1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          byte_q_next = text_byte;
          last_q_next = end_of_text;
          idx_next    = '0;
          if (word_pending && !in_ws && (word_count < cw)) begin
            // buffer one more word character
            ram_we          = 1'b1;
            word_count_next = word_count + 5'd1;
            if (end_of_text) begin
              rlen_next    = word_count + 5'd1;
              do_proc_next = 1'b0;
              state_next   = S_RCHK;
            end
          end else if (word_pending) begin
            // word ended (whitespace) or grew past the line width
            rlen_next    = in_ws ? word_count : word_count + 5'd1;
            do_proc_next = 1'b1;
            state_next   = S_RCHK;
          end else begin
            do_proc_next = 1'b1;
            state_next   = S_PROC;
          end
        end
      end

      S_RCHK: begin
        // the word fits a line but not the rest of this one when
        // line_length + rlen - 1 >= cw
        unit_b = rlen - 5'd1;
        if (!(len_ok && sum_ge) || out_free) begin
          if (len_ok && sum_ge) begin
            emit_en          = 1'b1;
            emit_kind        = KIND_BREAK;
            line_length_next = 5'd0;
          end
          if (word_count != 5'd0) begin
            state_next = S_RD;
          end else begin
            word_pending_next = 1'b0;
            state_next        = after_resolve;
          end
        end
      end

      S_RD: begin
        ram_re     = 1'b1;
        state_next = S_RCHR;
      end

      S_RCHR: begin
        if (out_free) begin
          emit_en          = 1'b1;
          emit_kind        = KIND_CHAR;
          emit_byte        = ram_rdata;
          line_length_next = sum[4:0];
          if (sum_ge) begin
            state_next = S_RBRK;
          end else if (idx_done) begin
            word_pending_next = 1'b0;
            word_count_next   = 5'd0;
            state_next        = after_resolve;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_RD;
          end
        end
      end

      S_RBRK: begin
        if (out_free) begin
          emit_en          = 1'b1;
          emit_kind        = KIND_BREAK;
          line_length_next = 5'd0;
          if (idx_done) begin
            word_pending_next = 1'b0;
            word_count_next   = 5'd0;
            state_next        = after_resolve;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_RD;
          end
        end
      end

      S_PROC: begin
        if (byte_q == NEWLINE_BYTE) begin
          if (out_free) begin
            emit_en          = 1'b1;
            emit_kind        = KIND_BREAK;
            line_length_next = 5'd0;
            state_next       = next_after;
          end
        end else if (byte_ws && (line_length == 5'd0)) begin
          // drop whitespace at the start of a line
          state_next = next_after;
        end else if (out_free) begin
          emit_en          = 1'b1;
          emit_kind        = KIND_CHAR;
          emit_byte        = byte_q;
          line_length_next = sum[4:0];
          if (sum_ge) begin
            state_next = S_PBRK;
          end else begin
            if (byte_ws && !last_q) begin
              // kept space: hold the next word until its length is known
              word_pending_next = 1'b1;
              word_count_next   = 5'd0;
            end
            state_next = next_after;
          end
        end
      end

      S_PBRK: begin
        if (out_free) begin
          emit_en          = 1'b1;
          emit_kind        = KIND_BREAK;
          line_length_next = 5'd0;
          state_next       = next_after;
        end
      end

      S_END: begin
        if (out_free) begin
          emit_en           = 1'b1;
          emit_kind         = KIND_END;
          emit_fin          = 1'b1;
          line_length_next  = 5'd0;
          word_pending_next = 1'b0;
          word_count_next   = 5'd0;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop once the sink takes it.
  always_comb begin
    out_valid_next    = out_valid;
    kind_next         = kind;
    out_byte_next     = out_byte;
    final_result_next = final_result;
    if (emit_en) begin
      out_valid_next    = 1'b1;
      kind_next         = emit_kind;
      out_byte_next     = emit_byte;
      final_result_next = emit_fin;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      columns      <= COLUMNS_RESET;
      line_length  <= 5'd0;
      word_pending <= 1'b0;
      word_count   <= 5'd0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      line_length  <= line_length_next;
      word_pending <= word_pending_next;
      word_count   <= word_count_next;
      out_valid    <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        columns <= cfg_data;
      end
    end
    byte_q       <= byte_q_next;
    last_q       <= last_q_next;
    do_proc      <= do_proc_next;
    rlen         <= rlen_next;
    idx          <= idx_next;
    kind         <= kind_next;
    out_byte     <= out_byte_next;
    final_result <= final_result_next;
  end

`ifndef SYNTHESIS
  // Buffered characters exist only while a word is pending.
  a_count_needs_pending: assert property (@(posedge clk) disable iff (rst)
    (word_count != 5'd0) |-> word_pending)
    else $error("word_count nonzero without a pending word");

  // The word count never exceeds the word store depth (MAX_COLUMNS).
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    word_count <= 5'(MAX_COLUMNS))
    else $error("word_count exceeds store depth");

  // The end flag rides only on the end marker.
  a_final_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_result) |-> (kind == KIND_END))
    else $error("final_result on a non-end result");

  // Breaks and end markers carry a zero byte.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_CHAR)) |-> (out_byte == 8'd0))
    else $error("nonzero byte on a break or end result");

  // An emitted end marker leaves the line empty and nothing pending.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (emit_en && (emit_kind == KIND_END)) |=> (line_length == 5'd0) && !word_pending)
    else $error("end marker did not clear line state");
`endif

endmodule

// ----- verif/wrap_check_pkg.sv -----
// Expected-output tracker for the greedy word wrap block.
package wrap_check_pkg;
  import gww_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       fin;
  } glyph_t;

  class wrap_tracker;
    logic [4:0] columns_reg;
    logic [4:0] line_len;
    logic       space_waiting;
    logic [7:0] word_buf [MAX_COLUMNS];
    logic [4:0] buf_fill;
    glyph_t     expected_glyphs [$];
    int unsigned mismatches;

    function new();
      columns_reg   = COLUMNS_RESET;
      line_len      = '0;
      space_waiting = 1'b0;
      buf_fill      = '0;
      mismatches    = 0;
    endfunction

    function void set_columns(logic [4:0] v);
      columns_reg = v;
    endfunction

    // Clamp the register into the usable range of columns.
    function int unsigned width();
      if (columns_reg == 5'd0) return 1;
      if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
      return columns_reg;
    endfunction

    function bit blank(logic [7:0] b);
      return (b == SPACE_BYTE) || (b >= TAB_BYTE && b <= CR_BYTE);
    endfunction

    function void push(kind_t k, logic [7:0] c, logic f);
      glyph_t g;
      g.kind = k;
      g.ch   = c;
      g.fin  = f;
      expected_glyphs.insert(expected_glyphs.size(), g);
    endfunction

    function void break_line();
      push(KIND_BREAK, 8'd0, 1'b0);
      line_len = '0;
    endfunction

    function void put_char(logic [7:0] b);
      push(KIND_CHAR, b, 1'b0);
      line_len = line_len + 5'd1;
      if (line_len >= width()) break_line();
    endfunction

    function void lay_byte(logic [7:0] b, bit last);
      if (b == NEWLINE_BYTE) begin
        break_line();
      end else if (blank(b) && line_len == 5'd0) begin
        // drop whitespace at the start of a line
      end else if (blank(b)) begin
        push(KIND_CHAR, b, 1'b0);
        line_len = line_len + 5'd1;
        if (line_len >= width()) begin
          break_line();
        end else if (!last) begin
          space_waiting = 1'b1;
          buf_fill      = '0;
        end
      end else begin
        put_char(b);
      end
    endfunction

    // Decide the break before a buffered word, then replay it.
    function void flush_word(int unsigned len);
      int unsigned cw;
      cw = width();
      if (len >= 1 && len <= cw && line_len + len > cw) break_line();
      for (int unsigned i = 0; i < buf_fill && i < MAX_COLUMNS; i++) put_char(word_buf[i]);
      space_waiting = 1'b0;
      buf_fill      = '0;
    endfunction

    // Note an accepted input transaction and queue the results it causes.
    function void take_byte(logic [7:0] b, bit last);
      if (space_waiting && !blank(b)) begin
        if (buf_fill < width() && buf_fill < MAX_COLUMNS) begin
          word_buf[buf_fill] = b;
          buf_fill = buf_fill + 5'd1;
          if (last) flush_word(buf_fill);
        end else begin
          flush_word(buf_fill + 1);
          lay_byte(b, last);
        end
      end else if (space_waiting) begin
        flush_word(buf_fill);
        lay_byte(b, last);
      end else begin
        lay_byte(b, last);
      end
      if (last) begin
        push(KIND_END, 8'd0, 1'b1);
        line_len      = '0;
        space_waiting = 1'b0;
        buf_fill      = '0;
      end
    endfunction

    function void note_miss(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // Check one output transaction against the oldest expected result.
    function void match_output(logic [1:0] k, logic [7:0] c, logic f);
      glyph_t got;
      glyph_t want;
      got.kind = kind_t'(k);
      got.ch   = c;
      got.fin  = f;
      if (expected_glyphs.size() == 0) begin
        note_miss($sformatf("unexpected result kind=%0d byte=%02h final=%0b", k, c, f));
        return;
      end
      want = expected_glyphs.pop_front();
      if (got !== want)
        note_miss($sformatf("expected kind=%0d byte=%02h final=%0b, got kind=%0d byte=%02h final=%0b",
                            want.kind, want.ch, want.fin, k, c, f));
    endfunction
  endclass

endpackage

// ----- verif/tb.sv -----
// Self-checking testbench for the greedy word wrap core.
module tb;
  import gww_pkg::*;
  import wrap_check_pkg::*;

  // Longest internal work after the last result: a full word replay plus slack.
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_COLUMNS + 16;
  localparam int unsigned RANDOM_ITEMS  = 370;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = '0;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       final_result;

  wrap_tracker tracker = new();

  // Text generator state: characters left in the current word.
  int unsigned word_left = 0;
  // Index into the list of forced column settings.
  int unsigned plan_idx = 0;

  greedy_word_wrap_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .final_result (final_result)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: hold out_ready for a random run, mostly short
  // stalls and long ready runs, now and then a long run at a random level.
  always @(posedge clk) begin : ready_gen
    int unsigned pick;
    int unsigned hold;
    if (hold != 0) begin
      hold = hold - 1;
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 16);
      end else if (pick < 9) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'($urandom_range(0, 1));
        hold = $urandom_range(10, 40);
      end
    end
  end

  // Check every result transaction; values sampled here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.match_output(kind, out_byte, final_result);
  end

  // Sender gap: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Force the extreme settings first, then mostly narrow areas so breaks are dense.
  function automatic logic [4:0] pick_columns();
    logic [4:0] plan [4];
    int unsigned r;
    plan = '{5'd0, 5'd31, 5'd24, 5'd1};
    if (plan_idx < 4) begin
      plan_idx++;
      return plan[plan_idx - 1];
    end
    r = $urandom_range(0, 9);
    if (r == 0) return 5'($urandom_range(0, 31));
    if (r == 1) return 5'($urandom_range(9, 16));
    return 5'($urandom_range(1, 8));
  endfunction

  function automatic logic [7:0] word_char();
    logic [7:0] b;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(97, 122));
    do b = 8'($urandom_range(0, 255)); while (tracker.blank(b));
    return b;
  endfunction

  // Next byte of a well-formed text: words of random length between single
  // whitespace bytes, with a small share of raw noise bytes.
  function automatic logic [7:0] next_text_byte();
    int unsigned r;
    logic [7:0] sep;
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    if (word_left != 0) begin
      word_left--;
      return word_char();
    end
    r = $urandom_range(0, 9);
    if (r < 6) sep = SPACE_BYTE;
    else if (r < 8) sep = 8'($urandom_range(TAB_BYTE, CR_BYTE));
    else sep = NEWLINE_BYTE;
    r = $urandom_range(0, 19);
    if (r < 2) word_left = 0;
    else if (r < 16) word_left = $urandom_range(1, 6);
    else if (r < 19) word_left = $urandom_range(7, 12);
    else word_left = $urandom_range(13, 20);
    return sep;
  endfunction

  // Drive one input transaction and note it once accepted. Leave in_valid
  // high afterwards so a back-to-back item needs no second assignment.
  task automatic send_item(input logic [7:0] b, input logic last, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= last;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(b, last);
  endtask

  task automatic send_string(input string s, input bit end_flag);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], end_flag && (i == s.len() - 1), pick_gap());
  endtask

  // Hold the sender until every expected result is out, then give the core
  // time to finish work that produces no result (buffered word characters).
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the core is idle.
  task automatic write_columns(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_columns(v);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned chunk;
    bit          burst;
    logic [7:0]  b;
    logic        last;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Narrow area: leading space dropped, break before a word that fits,
    // overlong word replayed without a break before it, byte extremes, newline,
    // and a space that ends the text.
    write_columns(5'd4);
    send_string(" ab cd\tefghi", 1'b0);
    send_item(8'hFF, 1'b0, pick_gap());
    send_item(8'h00, 1'b0, pick_gap());
    send_item(NEWLINE_BYTE, 1'b0, pick_gap());
    send_item(8'h7A, 1'b0, pick_gap());
    send_item(SPACE_BYTE, 1'b1, pick_gap());
    drain();

    // Narrow the area under a pending word, then end the text on that word.
    write_columns(5'd16);
    send_string("abcd gh", 1'b0);
    drain();
    write_columns(5'd3);
    send_item(8'h69, 1'b1, pick_gap());
    drain();

    // Random texts in chunks; a chunk may stop mid-text, so some column
    // changes land with a partial line or a buffered word in flight.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      chunk = $urandom_range(4, 28);
      for (int unsigned i = 0; i < chunk; i++) begin
        b = next_text_byte();
        if (i == chunk - 1) last = ($urandom_range(0, 2) != 0);
        else last = ($urandom_range(0, 49) == 0);
        send_item(b, last, burst ? 0 : pick_gap());
        sent++;
      end
      if ($urandom_range(0, 2) != 0) begin
        drain();
        if ($urandom_range(0, 1) != 0) write_columns(pick_columns());
      end
    end

    drain();
    if (tracker.mismatches == 0 && tracker.expected_glyphs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- greedy_word_wrap_core.f -----
src/gww_pkg.sv
src/gww_ram.sv
src/greedy_word_wrap_core.sv
verif/wrap_check_pkg.sv
verif/tb.sv
